/* hdl/fan_curve_stall_controller_core_assert.svh */
// Assertion macros shared by the checkers of the fan curve controller.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef FAN_CURVE_STALL_CONTROLLER_CORE_ASSERT_SVH
`define FAN_CURVE_STALL_CONTROLLER_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define FCSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcsc assertion failed");

// Consequent holds in the cycle after the antecedent.
`define FCSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcsc assertion failed");

`endif

/* hdl/fcsc_pkg.sv */
// Shared types, constants and helper functions of the fan curve controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fcsc_pkg;

  localparam int CURVE_POINTS_DEF = 5;

  localparam int TEMP_W     = 8;
  localparam int RPM_W      = 16;
  localparam int PCT_W      = 7;
  localparam int TICK_W     = 16;
  localparam int CURVE_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int STEP_W     = 3;
  localparam int DVD_W      = 14;
  localparam int DIV_CNT_W  = 4;

  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] CURVE_FAIL = 7'd97;

  localparam logic [CURVE_W-1:0] TEMPS_RST    = 40'd258455311360;
  localparam logic [CURVE_W-1:0] PERCENTS_RST = 40'd431009633300;
  localparam logic [RPM_W-1:0]   STALL_RPM_RST  = 16'd140;
  localparam logic [PCT_W-1:0]   OFF_PCT_RST    = 7'd5;
  localparam logic [TICK_W-1:0]  START_TICKS_RST = 16'd1000;
  localparam logic [TICK_W-1:0]  WAIT_TICKS_RST  = 16'd3000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_TEMPS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_PERCENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_RPM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_PERCENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_WAIT     = 3'd5;

  // Microcode step addresses
  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_ENDS   = 3'd1;
  localparam logic [STEP_W-1:0] S_SCAN   = 3'd2;
  localparam logic [STEP_W-1:0] S_MUL    = 3'd3;
  localparam logic [STEP_W-1:0] S_DIV    = 3'd4;
  localparam logic [STEP_W-1:0] S_FINISH = 3'd5;
  localparam logic [STEP_W-1:0] S_MODE   = 3'd6;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_STALL = 2'd1,
    MODE_START = 2'd2,
    MODE_ON    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_ENDS,
    OP_SCAN,
    OP_MUL,
    OP_DIV,
    OP_FINISH,
    OP_MODE
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_ENDS_HIT,
    C_SCAN_END,
    C_NO_SEG,
    C_DIV_DONE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] jump_t;
    logic [STEP_W-1:0] jump_f;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic ends_hit;
    logic scan_end;
    logic no_seg;
    logic div_done;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic [CURVE_W-1:0] curve_temps;
    logic [CURVE_W-1:0] curve_percents;
    logic [RPM_W-1:0]   stall_rpm;
    logic [PCT_W-1:0]   off_percent;
    logic [TICK_W-1:0]  start_ticks;
    logic [TICK_W-1:0]  stall_wait_ticks;
  } cfg_t;

  // Byte i of a curve register, clamped to 100; bytes past the register read 0.
  function automatic logic [PCT_W-1:0] curve_byte(input logic [CURVE_W-1:0] r,
                                                  input logic [2:0] i);
    logic [63:0] w;
    logic [7:0]  v;
    w = {24'd0, r};
    v = w[{i, 3'b000} +: 8];
    if (v > 8'd100) begin
      return PCT_FULL;
    end
    return v[PCT_W-1:0];
  endfunction

endpackage

/* hdl/fcsc_ucode_rom.sv */
// Control store of the fan curve controller: one control word per step.
// Depends on fcsc_pkg.
`timescale 1ns / 1ps

module fcsc_ucode_rom
  import fcsc_pkg::*;
(
  input  logic [STEP_W-1:0] step,
  output ucode_t            word
);

  always_comb begin
    case (step)
      S_IDLE:   word = '{op: OP_ACCEPT, cond: C_IN_VALID, jump_t: S_ENDS,   jump_f: S_IDLE};
      S_ENDS:   word = '{op: OP_ENDS,   cond: C_ENDS_HIT, jump_t: S_MODE,   jump_f: S_SCAN};
      S_SCAN:   word = '{op: OP_SCAN,   cond: C_SCAN_END, jump_t: S_MUL,    jump_f: S_SCAN};
      S_MUL:    word = '{op: OP_MUL,    cond: C_NO_SEG,   jump_t: S_MODE,   jump_f: S_DIV};
      S_DIV:    word = '{op: OP_DIV,    cond: C_DIV_DONE, jump_t: S_FINISH, jump_f: S_DIV};
      S_FINISH: word = '{op: OP_FINISH, cond: C_ALWAYS,   jump_t: S_MODE,   jump_f: S_MODE};
      S_MODE:   word = '{op: OP_MODE,   cond: C_OUT_FREE, jump_t: S_IDLE,   jump_f: S_MODE};
      default:  word = '{op: OP_ACCEPT, cond: C_ALWAYS,   jump_t: S_IDLE,   jump_f: S_IDLE};
    endcase
  end

endmodule

/* hdl/fcsc_sequencer.sv */
// Step counter of the fan curve controller: picks the next step from the
// control word's condition and jump targets. Depends on fcsc_pkg.
`timescale 1ns / 1ps

module fcsc_sequencer
  import fcsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ucode_t            word,
  input  flags_t            flags,
  output logic [STEP_W-1:0] step
);

  logic taken;

  always_comb begin
    case (word.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_VALID: taken = flags.in_valid;
      C_ENDS_HIT: taken = flags.ends_hit;
      C_SCAN_END: taken = flags.scan_end;
      C_NO_SEG:   taken = flags.no_seg;
      C_DIV_DONE: taken = flags.div_done;
      C_OUT_FREE: taken = flags.out_free;
      default:    taken = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= taken ? word.jump_t : word.jump_f;
    end
  end

endmodule

/* hdl/fcsc_datapath.sv */
// Datapath of the fan curve controller: curve lookup, serial divider, mode
// machine and output register, driven by the control word. Depends on fcsc_pkg.
`timescale 1ns / 1ps

module fcsc_datapath
  import fcsc_pkg::*;
#(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  ucode_t            word,
  input  logic              in_valid,
  input  logic [TEMP_W-1:0] in_temperature,
  input  logic [RPM_W-1:0]  in_measured_rpm,
  output logic              in_ready,
  output flags_t            flags,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PCT_W-1:0]  out_duty_percent,
  output logic [1:0]        out_mode,
  output logic [PCT_W-1:0]  out_curve_speed
);

  localparam int IDX_W = $clog2(CURVE_POINTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CURVE_POINTS - 2);
  localparam logic [2:0]       PT_LAST  = 3'(CURVE_POINTS - 1);

  logic [TEMP_W-1:0]    temp;
  logic [RPM_W-1:0]     rpm;
  logic [IDX_W-1:0]     idx;
  logic                 seg_found;
  logic [PCT_W-1:0]     p0;
  logic                 dp_neg;
  logic [PCT_W-1:0]     dp_mag;
  logic [PCT_W-1:0]     dt;
  logic [PCT_W-1:0]     den;
  logic [DVD_W-1:0]     dvd;
  logic [7:0]           rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PCT_W-1:0]     curve;
  mode_t                mode;
  logic [TICK_W-1:0]    tick;

  logic [PCT_W-1:0] t_first, t_last, p_first;
  logic [PCT_W-1:0] ta, tb, pa, pb;
  logic [2:0]       idx3;
  logic             seg_hit, seg_last, accept, out_free;
  logic [7:0]       rem_sh;
  logic [7:0]       q_adj;
  mode_t            mode_next;
  logic [TICK_W-1:0] tick_next;
  logic [TICK_W:0]  cnt;
  logic [PCT_W-1:0] duty;

  assign idx3    = 3'(idx);
  assign t_first = curve_byte(cfg.curve_temps, 3'd0);
  assign p_first = curve_byte(cfg.curve_percents, 3'd0);
  assign t_last  = curve_byte(cfg.curve_temps, PT_LAST);
  assign ta      = curve_byte(cfg.curve_temps, idx3);
  assign tb      = curve_byte(cfg.curve_temps, idx3 + 3'd1);
  assign pa      = curve_byte(cfg.curve_percents, idx3);
  assign pb      = curve_byte(cfg.curve_percents, idx3 + 3'd1);

  assign seg_hit  = (temp > {1'b0, ta}) && (temp <= {1'b0, tb});
  assign seg_last = (idx == IDX_LAST);
  assign in_ready = (word.op == OP_ACCEPT);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rem_sh   = {rem[6:0], dvd[DVD_W-1]};
  assign q_adj    = {1'b0, dvd[PCT_W-1:0]} + {7'd0, (dp_neg && (rem != 8'd0))};

  assign flags.in_valid = in_valid;
  assign flags.ends_hit = (temp <= {1'b0, t_first}) || (temp > {1'b0, t_last});
  assign flags.scan_end = seg_hit || seg_last;
  assign flags.no_seg   = !seg_found;
  assign flags.div_done = (div_cnt == DIV_CNT_W'(DVD_W - 1));
  assign flags.out_free = out_free;

  // Mode machine for the current tick
  always_comb begin
    mode_next = mode;
    tick_next = tick;
    duty      = '0;
    cnt       = {1'b0, tick} + 17'd1;
    case (mode)
      MODE_OFF: begin
        if (curve != '0) begin
          mode_next = MODE_START;
        end
      end
      MODE_START: begin
        duty = PCT_FULL;
        if (cnt >= {1'b0, cfg.start_ticks}) begin
          mode_next = MODE_ON;
        end else begin
          tick_next = cnt[TICK_W-1:0];
        end
      end
      MODE_ON: begin
        duty = curve;
        if (curve < cfg.off_percent) begin
          mode_next = MODE_OFF;
        end
        // stall wins over off
        if (rpm < cfg.stall_rpm) begin
          mode_next = MODE_STALL;
        end
      end
      MODE_STALL: begin
        if (cnt >= {1'b0, cfg.stall_wait_ticks}) begin
          mode_next = MODE_START;
        end else begin
          tick_next = cnt[TICK_W-1:0];
        end
      end
      default: begin
        mode_next = MODE_OFF;
      end
    endcase
    if (mode_next != mode) begin
      tick_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (word.op)
      OP_ACCEPT: begin
        if (accept) begin
          temp      <= in_temperature;
          rpm       <= in_measured_rpm;
          idx       <= '0;
          seg_found <= 1'b0;
        end
      end
      OP_ENDS: begin
        // fail-on value stands unless an end or a segment hits
        if (temp <= {1'b0, t_first}) begin
          curve <= p_first;
        end else if (temp > {1'b0, t_last}) begin
          curve <= PCT_FULL;
        end else begin
          curve <= CURVE_FAIL;
        end
      end
      OP_SCAN: begin
        if (seg_hit) begin
          seg_found <= 1'b1;
          p0        <= pa;
          den       <= tb - ta;
          dt        <= temp[PCT_W-1:0] - ta;
          dp_neg    <= (pb < pa);
          dp_mag    <= (pb < pa) ? (pa - pb) : (pb - pa);
        end else if (!seg_last) begin
          idx <= idx + IDX_W'(1);
        end
      end
      OP_MUL: begin
        dvd     <= DVD_W'(dt) * DVD_W'(dp_mag);
        rem     <= '0;
        div_cnt <= '0;
      end
      OP_DIV: begin
        // restoring division, one quotient bit per step
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          dvd <= {dvd[DVD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[DVD_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      OP_FINISH: begin
        // floor on a falling segment: round the magnitude up
        curve <= dp_neg ? (p0 - q_adj[PCT_W-1:0]) : (p0 + q_adj[PCT_W-1:0]);
      end
      OP_MODE: begin
        if (out_free) begin
          out_duty_percent <= duty;
          out_mode         <= mode_next;
          out_curve_speed  <= curve;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_OFF;
      tick      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (word.op == OP_MODE && out_free) begin
        mode      <= mode_next;
        tick      <= tick_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/fan_curve_stall_controller_core.sv */
// Fan controller with a five-point temperature curve and stall restart: one
// input word per sample tick yields one output word with duty, mode and curve
// speed. For each item the sequencer scans one curve segment a cycle and then
// runs a 14-step serial divider for the interpolation; a point outside the
// curve skips both.
// The output register lets the next tick be taken while a result waits.
// Depends on fcsc_pkg, fcsc_ucode_rom, fcsc_sequencer and fcsc_datapath.
`timescale 1ns / 1ps

module fan_curve_stall_controller_core
  import fcsc_pkg::*;
#(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // temperature[7:0], measured_rpm[23:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata   // duty_percent[6:0], mode[8:7], curve_speed[15:9]
);

  cfg_t              cfg;
  ucode_t            word;
  flags_t            flags;
  logic [STEP_W-1:0] step;
  logic [PCT_W-1:0]  duty;
  logic [1:0]        mode;
  logic [PCT_W-1:0]  curve;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curve_temps      <= TEMPS_RST;
      cfg.curve_percents   <= PERCENTS_RST;
      cfg.stall_rpm        <= STALL_RPM_RST;
      cfg.off_percent      <= OFF_PCT_RST;
      cfg.start_ticks      <= START_TICKS_RST;
      cfg.stall_wait_ticks <= WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_TEMPS:    cfg.curve_temps      <= cfg_data[CURVE_W-1:0];
        CFG_CURVE_PERCENTS: cfg.curve_percents   <= cfg_data[CURVE_W-1:0];
        CFG_STALL_RPM:      cfg.stall_rpm        <= cfg_data[RPM_W-1:0];
        CFG_OFF_PERCENT:    cfg.off_percent      <= cfg_data[PCT_W-1:0];
        CFG_START_TICKS:    cfg.start_ticks      <= cfg_data[TICK_W-1:0];
        CFG_STALL_WAIT:     cfg.stall_wait_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fcsc_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  fcsc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .word  (word),
    .flags (flags),
    .step  (step)
  );

  fcsc_datapath #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .word             (word),
    .in_valid         (s_axis_tvalid),
    .in_temperature   (s_axis_tdata[7:0]),
    .in_measured_rpm  (s_axis_tdata[23:8]),
    .in_ready         (s_axis_tready),
    .flags            (flags),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_duty_percent (duty),
    .out_mode         (mode),
    .out_curve_speed  (curve)
  );

  assign m_axis_tdata = {curve, mode, duty};

endmodule

/* hdl/fcsc_checker.sv */
// Port-level checker of the fan curve controller, bound to the top level.
// Depends on fan_curve_stall_controller_core_assert.svh and fcsc_pkg.
`timescale 1ns / 1ps
`include "fan_curve_stall_controller_core_assert.svh"

module fcsc_checker
  import fcsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [15:0]           m_axis_tdata
);

  logic [6:0] duty;
  logic [1:0] mode;
  logic [6:0] curve;

  assign duty  = m_axis_tdata[6:0];
  assign mode  = m_axis_tdata[8:7];
  assign curve = m_axis_tdata[15:9];

  // hold a stalled word
  `FCSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // one tick at a time: input closes right after a take
  `FCSC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `FCSC_ASSERT_NOW(a_range, m_axis_tvalid, duty <= 7'd100 && curve <= 7'd100)
  `FCSC_ASSERT_NOW(a_duty_src, m_axis_tvalid, duty == 7'd0 || duty == 7'd100 || duty == curve)
  `FCSC_ASSERT_NOW(a_start_duty, m_axis_tvalid && mode == MODE_START, duty == 7'd0 || duty == 7'd100)

endmodule

bind fan_curve_stall_controller_core fcsc_checker u_fcsc_checker (.*);
